@@ rtl/multi_key_debounce_press_events_core_macros.svh @@
// Assertion helpers for the key debouncer; they expect clk and rst in scope.
`ifndef MULTI_KEY_DEBOUNCE_PRESS_EVENTS_CORE_MACROS_SVH
`define MULTI_KEY_DEBOUNCE_PRESS_EVENTS_CORE_MACROS_SVH

// Same-cycle implication
`define MKDPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debouncer assertion failed (same cycle)");

// Next-cycle implication
`define MKDPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debouncer assertion failed (next cycle)");

`endif

@@ rtl/mkdpe_pkg.sv @@
package mkdpe_pkg;

  // Key count is fixed by the six pin and enable bits
  localparam int NUM_KEYS = 6;
  localparam int KEY_W    = $clog2(NUM_KEYS + 1);
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;

  // Operation codes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Configuration register indexes
  localparam logic REG_DEBOUNCE_MS = 1'b0;
  localparam logic REG_KEY_ENABLE  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = DEB_W'(30);
  localparam logic [NUM_KEYS-1:0] ENABLE_RESET   = '1;

  // Per-key status passed from a lane to the merge stage
  typedef struct packed {
    logic stable_next;  // debounced level after the current transaction
    logic pending;      // press waiting to be taken (before this transaction)
  } lane_stat_t;

endpackage

@@ rtl/mkdpe_lane.sv @@
module mkdpe_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        scan,
  input  logic                        take_clr,
  input  logic                        pressed,
  input  logic [mkdpe_pkg::TIME_W-1:0] now_ms,
  input  logic [mkdpe_pkg::DEB_W-1:0]  debounce_ms,
  output mkdpe_pkg::lane_stat_t       stat
);
  import mkdpe_pkg::*;

  logic              stable;
  logic              stable_next;
  logic              pending;
  logic              pending_next;
  logic [TIME_W-1:0] change_start;
  logic [TIME_W-1:0] change_start_next;
  logic [TIME_W-1:0] elapsed;

  // Elapsed time since the change was first seen, modulo 2^32
  assign elapsed = now_ms - change_start;

  // Debounce decision for one key
  always_comb begin
    stable_next       = stable;
    pending_next      = pending;
    change_start_next = change_start;
    if (scan) begin
      if (pressed != stable) begin
        if (change_start == '0) begin
          change_start_next = now_ms;
        end else if (elapsed >= TIME_W'(debounce_ms)) begin
          stable_next       = pressed;
          change_start_next = '0;
          if (pressed) begin
            pending_next = 1'b1;
          end
        end
      end else begin
        change_start_next = '0;
      end
    end else if (take_clr) begin
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable       <= 1'b0;
      pending      <= 1'b0;
      change_start <= '0;
    end else begin
      stable       <= stable_next;
      pending      <= pending_next;
      change_start <= change_start_next;
    end
  end

  assign stat.stable_next = stable_next;
  assign stat.pending     = pending;

endmodule

@@ rtl/mkdpe_merge.sv @@
module mkdpe_merge (
  input  mkdpe_pkg::lane_stat_t [mkdpe_pkg::NUM_KEYS-1:0] stat,
  output logic [mkdpe_pkg::NUM_KEYS-1:0]                  take_sel,
  output logic                                            take_found,
  output logic [mkdpe_pkg::KEY_W-1:0]                     take_key,
  output logic [mkdpe_pkg::NUM_KEYS-1:0]                  mask,
  output logic [mkdpe_pkg::KEY_W-1:0]                     active
);
  import mkdpe_pkg::*;

  // Lowest-index pending press and lowest stably pressed key
  always_comb begin
    take_sel   = '0;
    take_found = 1'b0;
    take_key   = '0;
    mask       = '0;
    active     = KEY_W'(NUM_KEYS);
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      mask[i] = stat[i].stable_next;
      if (stat[i].stable_next) begin
        active = KEY_W'(i);
      end
      if (stat[i].pending) begin
        take_found = 1'b1;
        take_key   = KEY_W'(i);
      end
    end
    if (take_found) begin
      take_sel[take_key] = 1'b1;
    end
  end

endmodule

@@ rtl/multi_key_debounce_press_events_core.sv @@
// Each result is registered and presented in the cycle after its transaction.
// Throughput: one transaction per cycle unless out_ready stalls; all six key
// lanes update together; the output register refills as the old one is taken.
// Reset (rst, synchronous): keys released, no timing, no pending presses,
// debounce_ms = 30, key_enable = all ones, no result held.
`include "multi_key_debounce_press_events_core_macros.svh"

module multi_key_debounce_press_events_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mkdpe_pkg::DEB_W-1:0]       cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [mkdpe_pkg::TIME_W-1:0]      now_ms,
  input  logic [mkdpe_pkg::NUM_KEYS-1:0]    pin_levels,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mkdpe_pkg::NUM_KEYS-1:0]    stable_mask,
  output logic [mkdpe_pkg::KEY_W-1:0]       active_key,
  output logic                              event_valid,
  output logic [mkdpe_pkg::KEY_W-1:0]       event_key
);
  import mkdpe_pkg::*;

  logic [DEB_W-1:0]    debounce_ms;
  logic [NUM_KEYS-1:0] key_enable;

  logic                in_fire;
  logic                scan;
  logic                take;
  lane_stat_t [NUM_KEYS-1:0] stat;
  logic [NUM_KEYS-1:0] pending_vec;
  logic [NUM_KEYS-1:0] take_sel;
  logic                take_found;
  logic [KEY_W-1:0]    take_key;
  logic [NUM_KEYS-1:0] mask;
  logic [KEY_W-1:0]    active;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      key_enable  <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_MS: debounce_ms <= cfg_data;
        REG_KEY_ENABLE:  key_enable  <= cfg_data[NUM_KEYS-1:0];
        default:         ;
      endcase
    end
  end

  // Handshake: new transaction whenever the output slot is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign scan     = in_fire && (op == OP_SCAN);
  assign take     = in_fire && (op == OP_TAKE);

  // One lane per key
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    mkdpe_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .scan        (scan),
      .take_clr    (take && take_sel[g]),
      .pressed     (key_enable[g] && !pin_levels[g]),
      .now_ms      (now_ms),
      .debounce_ms (debounce_ms),
      .stat        (stat[g])
    );
    assign pending_vec[g] = stat[g].pending;
  end

  mkdpe_merge u_merge (
    .stat       (stat),
    .take_sel   (take_sel),
    .take_found (take_found),
    .take_key   (take_key),
    .mask       (mask),
    .active     (active)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stable_mask <= mask;
      active_key  <= active;
      event_valid <= take && take_found;
      event_key   <= take ? take_key : '0;
    end
  end

  // Checks
  `MKDPE_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid)
  `MKDPE_ASSERT_NOW(a_active_matches_mask, out_valid,
    (stable_mask == '0) == (active_key == KEY_W'(NUM_KEYS)))
  `MKDPE_ASSERT_NOW(a_event_key_range, out_valid && event_valid,
    event_key < KEY_W'(NUM_KEYS))
  `MKDPE_ASSERT_NEXT(a_take_clears_one, take && take_found,
    $countones(pending_vec) + 1 == $past($countones(pending_vec)))

endmodule

@@ verif/tb_multi_key_debounce_press_events_core.sv @@
`timescale 1ns / 1ps

module tb_multi_key_debounce_press_events_core;
  import mkdpe_pkg::*;

  // Expected result of one transaction
  typedef struct packed {
    logic [NUM_KEYS-1:0] mask;
    logic [KEY_W-1:0]    act;
    logic                ev;
    logic [KEY_W-1:0]    key;
  } keys_res_t;

  // One row of the directed table: a register write or an input transaction
  typedef struct {
    bit                  is_cfg;
    logic                ridx;
    logic [DEB_W-1:0]    rdata;
    logic                o;
    logic [TIME_W-1:0]   t;
    logic [NUM_KEYS-1:0] pins;
    bit                  typed;
    keys_res_t           want;
  } dir_row_t;

  localparam keys_res_t NONE_RES  = {6'h00, 3'd6, 1'b0, 3'd0};
  localparam int        QUIET_MAX = 1000;
  localparam int        N_PHASES  = 12;
  localparam int        PHASE_LEN = 125;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_DEBOUNCE_MS;
  logic [DEB_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_SCAN;
  logic [TIME_W-1:0]     now_ms = '0;
  logic [NUM_KEYS-1:0]   pin_levels = '1;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [NUM_KEYS-1:0]   stable_mask;
  logic [KEY_W-1:0]      active_key;
  logic                  event_valid;
  logic [KEY_W-1:0]      event_key;

  // Typed expectation travels with the payload
  bit                    typed_row = 1'b0;
  keys_res_t             typed_want = '0;

  // Predictor state and register copies
  logic [DEB_W-1:0]      deb_ms = DEBOUNCE_RESET;
  logic [NUM_KEYS-1:0]   key_en = ENABLE_RESET;
  logic [NUM_KEYS-1:0]   key_stable = '0;
  logic [NUM_KEYS-1:0]   key_pend = '0;
  logic [TIME_W-1:0]     key_t0 [NUM_KEYS];

  keys_res_t             key_status_q [$];
  dir_row_t              dir_q [$];
  int                    n_sent = 0;
  int                    n_checked = 0;
  int                    err_cnt = 0;
  int                    quiet = 0;
  keys_res_t             got, seen;

  multi_key_debounce_press_events_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .now_ms      (now_ms),
    .pin_levels  (pin_levels),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stable_mask (stable_mask),
    .active_key  (active_key),
    .event_valid (event_valid),
    .event_key   (event_key)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (key_t0[k]) key_t0[k] = '0;
  end

  // Debounce one scan or take one press, return the status after it
  function automatic keys_res_t next_key_status(logic o, logic [TIME_W-1:0] t,
                                                logic [NUM_KEYS-1:0] pins);
    keys_res_t         r;
    logic              prs;
    logic [TIME_W-1:0] held;
    r = '0;
    r.act = KEY_W'(NUM_KEYS);
    if (o == OP_SCAN) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        prs = key_en[k] & ~pins[k];
        if (prs != key_stable[k]) begin
          held = t - key_t0[k];
          // zero start time means nothing is being timed yet
          if (key_t0[k] == '0) begin
            key_t0[k] = t;
          end else if (held >= {{(TIME_W-DEB_W){1'b0}}, deb_ms}) begin
            if (prs) key_pend[k] = 1'b1;
            key_stable[k] = prs;
            key_t0[k] = '0;
          end
        end else begin
          key_t0[k] = '0;
        end
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (key_pend[k] && !r.ev) begin
          key_pend[k] = 1'b0;
          r.ev = 1'b1;
          r.key = KEY_W'(k);
        end
      end
    end
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (key_stable[k]) begin
        r.mask[k] = 1'b1;
        r.act = KEY_W'(k);
      end
    end
    return r;
  endfunction

  // Predict on each accepted input, compare on each accepted output
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (key_status_q.size() == 0) begin
          $error("result with no expectation waiting: mask %h key %0d", stable_mask,
                 active_key);
          err_cnt++;
        end else begin
          seen = key_status_q.pop_front();
          if (stable_mask !== seen.mask) begin
            $error("stable_mask: expected %h, got %h", seen.mask, stable_mask);
            err_cnt++;
          end
          if (active_key !== seen.act) begin
            $error("active_key: expected %0d, got %0d", seen.act, active_key);
            err_cnt++;
          end
          if (event_valid !== seen.ev) begin
            $error("event_valid: expected %b, got %b", seen.ev, event_valid);
            err_cnt++;
          end
          if (event_key !== seen.key) begin
            $error("event_key: expected %0d, got %0d", seen.key, event_key);
            err_cnt++;
          end
        end
        n_checked++;
      end
      if (in_valid && in_ready) begin
        got = next_key_status(op, now_ms, pin_levels);
        key_status_q.push_back(typed_row ? typed_want : got);
      end
    end
  end

  // Receiver: modes of free flow, coin toss, sparse and long stalls
  int rx_mode = 0;
  int rx_left = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= 1'b1;
          rx_hold = $urandom_range(0, 20);
        end else begin
          out_ready <= 1'b0;
          rx_hold--;
        end
      end
    endcase
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void dir_cfg(logic ri, logic [DEB_W-1:0] rd);
    dir_row_t r;
    r = '{is_cfg: 1'b1, ridx: ri, rdata: rd, o: OP_SCAN, t: '0, pins: '1,
          typed: 1'b0, want: '0};
    dir_q.push_back(r);
  endfunction

  function automatic void dir_item(logic o, logic [TIME_W-1:0] t, logic [NUM_KEYS-1:0] p,
                                   bit ty, keys_res_t w);
    dir_row_t r;
    r = '{is_cfg: 1'b0, ridx: REG_DEBOUNCE_MS, rdata: '0, o: o, t: t, pins: p,
          typed: ty, want: w};
    dir_q.push_back(r);
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(logic o, logic [TIME_W-1:0] t, logic [NUM_KEYS-1:0] p, bit ty,
                      keys_res_t w);
    bit hs;
    in_valid   <= 1'b1;
    op         <= o;
    now_ms     <= t;
    pin_levels <= p;
    typed_row  <= ty;
    typed_want <= w;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
    n_sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic ri, logic [DEB_W-1:0] rd);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= rd;
    if (ri == REG_DEBOUNCE_MS) deb_ms = rd;
    else key_en = rd[NUM_KEYS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    logic [TIME_W-1:0]   t_now, t;
    logic [NUM_KEYS-1:0] pat, p;
    logic                o;
    int                  burst, pick;
    bit                  nogap;

    // Directed: sentinel start, threshold, takes, wrap, zero and max debounce,
    // disabled keys, take with nothing pending
    dir_item(OP_TAKE, 32'd0, 6'h3F, 1'b1, NONE_RES);
    dir_item(OP_SCAN, 32'd0, 6'h00, 1'b1, NONE_RES);
    dir_item(OP_SCAN, 32'd100, 6'h00, 1'b1, NONE_RES);
    dir_item(OP_SCAN, 32'd129, 6'h00, 1'b1, NONE_RES);
    dir_item(OP_SCAN, 32'd130, 6'h00, 1'b1, {6'h3F, 3'd0, 1'b0, 3'd0});
    dir_item(OP_TAKE, 32'hFFFF_FFFF, 6'h00, 1'b1, {6'h3F, 3'd0, 1'b1, 3'd0});
    dir_item(OP_TAKE, 32'd0, 6'h3F, 1'b1, {6'h3F, 3'd0, 1'b1, 3'd1});
    dir_item(OP_SCAN, 32'd200, 6'h01, 1'b0, '0);
    dir_item(OP_SCAN, 32'd210, 6'h00, 1'b0, '0);
    dir_item(OP_SCAN, 32'd240, 6'h01, 1'b0, '0);
    dir_item(OP_SCAN, 32'hFFFF_FFFF, 6'h01, 1'b0, '0);
    dir_cfg(REG_DEBOUNCE_MS, 16'h0000);
    dir_item(OP_SCAN, 32'd5, 6'h3F, 1'b0, '0);
    dir_item(OP_SCAN, 32'd5, 6'h3F, 1'b1, NONE_RES);
    dir_cfg(REG_KEY_ENABLE, 16'hFFC0);
    dir_item(OP_SCAN, 32'd6, 6'h00, 1'b1, NONE_RES);
    dir_item(OP_SCAN, 32'd7, 6'h00, 1'b1, NONE_RES);
    dir_cfg(REG_KEY_ENABLE, 16'h003F);
    dir_cfg(REG_DEBOUNCE_MS, 16'hFFFF);
    dir_item(OP_SCAN, 32'd10, 6'h00, 1'b0, '0);
    dir_item(OP_SCAN, 32'd65544, 6'h00, 1'b0, '0);
    dir_item(OP_SCAN, 32'd65545, 6'h00, 1'b0, '0);
    dir_cfg(REG_KEY_ENABLE, 16'h002A);
    dir_item(OP_SCAN, 32'd70000, 6'h00, 1'b0, '0);
    dir_item(OP_SCAN, 32'd135535, 6'h00, 1'b0, '0);
    repeat (4) dir_item(OP_TAKE, 32'd0, 6'h00, 1'b0, '0);
    dir_item(OP_SCAN, 32'hAAAA_AAAA, 6'h2A, 1'b0, '0);
    dir_cfg(REG_DEBOUNCE_MS, DEBOUNCE_RESET);
    dir_cfg(REG_KEY_ENABLE, 16'(ENABLE_RESET));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        wait_idle();
        write_reg(dir_q[i].ridx, dir_q[i].rdata);
      end else begin
        send(dir_q[i].o, dir_q[i].t, dir_q[i].pins, dir_q[i].typed, dir_q[i].want);
      end
    end

    // Random phases: held pin patterns with bounce, advancing time, takes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      pick = (ph < 2) ? ph : $urandom_range(2, 7);
      case (pick)
        0:       write_reg(REG_DEBOUNCE_MS, 16'h0000);
        1:       write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
        default: write_reg(REG_DEBOUNCE_MS, 16'($urandom_range(1, 40)));
      endcase
      pick = (ph == 3) ? 0 : $urandom_range(0, 7);
      case (pick)
        0:       write_reg(REG_KEY_ENABLE, {10'($urandom), 6'h00});
        1, 2, 3: write_reg(REG_KEY_ENABLE, {10'($urandom), 6'h3F});
        default: write_reg(REG_KEY_ENABLE, 16'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       t_now = '0;
        1:       t_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
        default: t_now = $urandom;
      endcase
      pat   = $urandom;
      nogap = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(1, 30);
      for (int n = 0; n < PHASE_LEN; n++) begin
        o = ($urandom_range(0, 3) == 0) ? OP_TAKE : OP_SCAN;
        if ($urandom_range(0, 7) == 0) pat = $urandom;
        t_now = t_now + $urandom_range(0, deb_ms / 4 + 3);
        t = ($urandom_range(0, 39) == 0) ? $urandom : t_now;
        p = pat;
        if ($urandom_range(0, 5) == 0) p[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
        if (o == OP_TAKE) begin
          t = $urandom;
          p = $urandom;
        end
        send(o, t, p, 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if (!nogap) pause($urandom_range(1, 8));
        end
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (key_status_q.size() != 0) begin
      $error("%0d expected results never arrived", key_status_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
